// ===== rtl/srrg_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srrg_pkg
// Shared types and constants of the sensor receive-rate grader.
// ============================================================================
package srrg_pkg;

    // Default sizes
    localparam int RING_DEPTH_DEF  = 64;
    localparam int NUM_SENSORS_DEF = 4;

    // Field widths
    localparam int SENSOR_W  = 2;
    localparam int TIME_W    = 48;
    localparam int WINDOW_W  = 26;
    localparam int SAMPLES_W = 7;
    localparam int THR_W     = 20;
    localparam int QUAL_W    = 3;
    localparam int APB_AW    = 5;
    localparam int APB_DW    = 32;

    // Shared multiplier operand widths
    localparam int MUL_A_W = 30;
    localparam int MUL_B_W = 22;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int RHS_W   = 64;

    // Register reset values
    localparam logic [WINDOW_W-1:0]  WINDOW_RST      = 26'd2000000;
    localparam logic [SAMPLES_W-1:0] MIN_SAMPLES_RST = 7'd5;
    localparam logic [THR_W-1:0]     TOF_MIN_RST     = 20'd5000;
    localparam logic [THR_W-1:0]     TOF_GOOD_RST    = 20'd8000;
    localparam logic [THR_W-1:0]     TOF_EXC_RST     = 20'd9000;
    localparam logic [THR_W-1:0]     DEPTH_MIN_RST   = 20'd5000;
    localparam logic [THR_W-1:0]     DEPTH_GOOD_RST  = 20'd10000;
    localparam logic [THR_W-1:0]     DEPTH_EXC_RST   = 20'd12000;

    // Substitutes for out-of-range register values
    localparam logic [WINDOW_W-1:0]  WINDOW_SUB      = 26'd2000000;
    localparam logic [SAMPLES_W-1:0] MIN_SAMPLES_SUB = 7'd5;
    localparam logic [SAMPLES_W-1:0] MIN_SAMPLES_LOW = 7'd2;
    localparam logic [THR_W-1:0]     MIN_MHZ_SUB     = 20'd5000;

    // One hertz in millihertz times one second in microseconds
    localparam logic [MUL_A_W-1:0] RATE_SCALE = 30'd1000000000;

    typedef enum logic [2:0] {
        REG_WINDOW      = 3'd0,
        REG_MIN_SAMPLES = 3'd1,
        REG_TOF_MIN     = 3'd2,
        REG_TOF_GOOD    = 3'd3,
        REG_TOF_EXC     = 3'd4,
        REG_DEPTH_MIN   = 3'd5,
        REG_DEPTH_GOOD  = 3'd6,
        REG_DEPTH_EXC   = 3'd7
    } t_reg_idx;

    typedef enum logic [SENSOR_W-1:0] {
        SENS_DEPTH = 2'd0,
        SENS_TOF_L = 2'd1,
        SENS_TOF_R = 2'd2,
        SENS_ULTRA = 2'd3
    } t_sensor;

    typedef enum logic [QUAL_W-1:0] {
        Q_NA        = 3'd0,
        Q_ESTAB     = 3'd1,
        Q_BELOW     = 3'd2,
        Q_MINIMUM   = 3'd3,
        Q_GOOD      = 3'd4,
        Q_EXCELLENT = 3'd5
    } t_quality;

    typedef enum logic [1:0] {
        THR_MIN  = 2'd0,
        THR_GOOD = 2'd1,
        THR_EXC  = 2'd2
    } t_thr_sel;

endpackage
`default_nettype wire

// ===== rtl/srrg_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// srrg_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ============================================================================
module srrg_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule
`default_nettype wire

// ===== rtl/sensor_receive_rate_grader_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ============================================================================
// sensor_receive_rate_grader_unit
// Keeps a timestamp ring per sensor and grades each sensor's receive rate.
// ============================================================================
// Each input word is one receipt event (sensor, time in us) and yields exactly
// one result word. The block works on one word at a time: o_in_stall stays
// high from acceptance until the result has been moved into the output
// register, which then waits for the consumer while the next word may enter.
// From acceptance to a valid result a word passes through the push, the pruning
// of old timestamps from the ring (each costs one read of the timestamp RAM and
// one age compare) and up to three rate thresholds tried on the single shared
// 30x22 multiplier. Timestamps live in one RAM of NUM_SENSORS*RING_DEPTH words;
// it needs no clearing after reset.
module sensor_receive_rate_grader_unit
    import srrg_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // Input channel
    input  wire logic                 i_in_valid,
    output logic                      o_in_stall,
    input  wire logic [SENSOR_W-1:0]  i_sensor,
    input  wire logic [TIME_W-1:0]    i_time_us,
    // Output channel
    output logic                      o_out_valid,
    input  wire logic                 i_out_stall,
    output logic [SENSOR_W-1:0]       o_sensor_out,
    output logic [QUAL_W-1:0]         o_quality,
    output logic                      o_rate_ok,
    output logic [SAMPLES_W-1:0]      o_sample_count,
    output logic [TIME_W-1:0]         o_span_us,
    output logic                      o_overflow_drop,
    // Configuration port
    input  wire logic                 psel,
    input  wire logic                 penable,
    input  wire logic                 pwrite,
    input  wire logic [APB_AW-1:0]    paddr,
    input  wire logic [APB_DW-1:0]    pwdata,
    output logic      [APB_DW-1:0]    prdata,
    output logic                      pready
);

    localparam int HEAD_W = $clog2(RING_DEPTH);
    localparam int CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int SUM_W  = HEAD_W + 1;
    localparam int MEM_D  = NUM_SENSORS * RING_DEPTH;
    localparam int AW     = $clog2(MEM_D);
    localparam int SIDX_W = $clog2(NUM_SENSORS);
    localparam int CMP_W  = (CNT_W > SAMPLES_W) ? CNT_W : SAMPLES_W;

    localparam logic [HEAD_W-1:0] HEAD_LAST = HEAD_W'(RING_DEPTH - 1);
    localparam logic [CNT_W-1:0]  CNT_FULL  = CNT_W'(RING_DEPTH);
    localparam logic [CNT_W-1:0]  CNT_ONE   = CNT_W'(1);
    localparam logic [CNT_W-1:0]  CNT_TWO   = CNT_W'(2);
    localparam logic [SUM_W-1:0]  SUM_WRAP  = SUM_W'(RING_DEPTH);
    localparam logic [AW-1:0]     RING_D_A  = AW'(RING_DEPTH);

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_PUSH = 9'b000000010,
        S_RD   = 9'b000000100,
        S_CHK  = 9'b000001000,
        S_MLHS = 9'b000010000,
        S_MLO  = 9'b000100000,
        S_MHI  = 9'b001000000,
        S_CMP  = 9'b010000000,
        S_DONE = 9'b100000000
    } t_state;

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0]  r_window;
    logic [SAMPLES_W-1:0] r_min_samples;
    logic [THR_W-1:0]     r_tof_min, r_tof_good, r_tof_exc;
    logic [THR_W-1:0]     r_depth_min, r_depth_good, r_depth_exc;

    logic     w_cfg_wr;
    t_reg_idx w_reg_idx;

    assign pready    = 1'b1;
    assign w_reg_idx = t_reg_idx'(paddr[APB_AW-1:2]);
    assign w_cfg_wr  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_window      <= WINDOW_RST;
            r_min_samples <= MIN_SAMPLES_RST;
            r_tof_min     <= TOF_MIN_RST;
            r_tof_good    <= TOF_GOOD_RST;
            r_tof_exc     <= TOF_EXC_RST;
            r_depth_min   <= DEPTH_MIN_RST;
            r_depth_good  <= DEPTH_GOOD_RST;
            r_depth_exc   <= DEPTH_EXC_RST;
        end else if (w_cfg_wr) begin
            unique case (w_reg_idx)
                REG_WINDOW:      r_window      <= pwdata[WINDOW_W-1:0];
                REG_MIN_SAMPLES: r_min_samples <= pwdata[SAMPLES_W-1:0];
                REG_TOF_MIN:     r_tof_min     <= pwdata[THR_W-1:0];
                REG_TOF_GOOD:    r_tof_good    <= pwdata[THR_W-1:0];
                REG_TOF_EXC:     r_tof_exc     <= pwdata[THR_W-1:0];
                REG_DEPTH_MIN:   r_depth_min   <= pwdata[THR_W-1:0];
                REG_DEPTH_GOOD:  r_depth_good  <= pwdata[THR_W-1:0];
                REG_DEPTH_EXC:   r_depth_exc   <= pwdata[THR_W-1:0];
                default:         r_window      <= r_window;
            endcase
        end
    end

    always_comb begin
        unique case (w_reg_idx)
            REG_WINDOW:      prdata = APB_DW'(r_window);
            REG_MIN_SAMPLES: prdata = APB_DW'(r_min_samples);
            REG_TOF_MIN:     prdata = APB_DW'(r_tof_min);
            REG_TOF_GOOD:    prdata = APB_DW'(r_tof_good);
            REG_TOF_EXC:     prdata = APB_DW'(r_tof_exc);
            REG_DEPTH_MIN:   prdata = APB_DW'(r_depth_min);
            REG_DEPTH_GOOD:  prdata = APB_DW'(r_depth_good);
            REG_DEPTH_EXC:   prdata = APB_DW'(r_depth_exc);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Effective settings
    // ------------------------------------------------------------------
    logic [WINDOW_W-1:0]  w_window;
    logic [SAMPLES_W-1:0] w_need;
    logic [THR_W-1:0]     w_min_raw, w_good_raw, w_exc_raw;
    logic [THR_W-1:0]     w_min, w_good, w_exc, w_thr;

    assign w_window = (r_window == '0) ? WINDOW_SUB : r_window;
    assign w_need   = (r_min_samples >= MIN_SAMPLES_LOW) ? r_min_samples : MIN_SAMPLES_SUB;

    // State fields are declared here so the threshold set can follow the sensor.
    t_state               r_state;
    logic [SENSOR_W-1:0]  r_sens;
    logic [TIME_W-1:0]    r_time;
    logic [HEAD_W-1:0]    r_head;
    logic [CNT_W-1:0]     r_cnt;
    logic                 r_drop;
    logic [TIME_W-1:0]    r_span;
    logic [1:0]           r_k;
    t_quality             r_qual;
    logic [PROD_W-1:0]    r_prod;
    logic [PROD_W-1:0]    r_lhs;
    logic [PROD_W-1:0]    r_acc;

    assign w_min_raw  = (r_sens == SENS_DEPTH) ? r_depth_min  : r_tof_min;
    assign w_good_raw = (r_sens == SENS_DEPTH) ? r_depth_good : r_tof_good;
    assign w_exc_raw  = (r_sens == SENS_DEPTH) ? r_depth_exc  : r_tof_exc;
    assign w_min      = (w_min_raw == '0) ? MIN_MHZ_SUB : w_min_raw;
    assign w_good     = (w_good_raw < w_min) ? w_min : w_good_raw;
    assign w_exc      = (w_exc_raw < w_good) ? w_good : w_exc_raw;

    always_comb begin
        case (t_thr_sel'(r_k))
            THR_MIN:  w_thr = w_min;
            THR_GOOD: w_thr = w_good;
            default:  w_thr = w_exc;
        endcase
    end

    // ------------------------------------------------------------------
    // Per-sensor ring pointers
    // ------------------------------------------------------------------
    logic [HEAD_W-1:0] r_head_a [NUM_SENSORS];
    logic [CNT_W-1:0]  r_cnt_a  [NUM_SENSORS];

    // ------------------------------------------------------------------
    // Datapath
    // ------------------------------------------------------------------
    logic              w_accept;
    logic              w_load;
    logic              w_full;
    logic [HEAD_W-1:0] w_head_inc;
    logic [HEAD_W-1:0] w_head_d;
    logic [CNT_W-1:0]  w_cnt_d;
    logic [SUM_W-1:0]  w_slot_sum;
    logic [HEAD_W-1:0] w_slot;
    logic [AW-1:0]     w_base;
    logic [AW-1:0]     w_waddr;
    logic [AW-1:0]     w_raddr;
    logic [TIME_W-1:0] w_rdata;
    logic [TIME_W-1:0] w_age;
    logic              w_prune;
    logic              w_few;
    logic              w_no_rate;
    logic [MUL_A_W-1:0] w_mul_a;
    logic [MUL_B_W-1:0] w_mul_b;
    logic [RHS_W-1:0]  w_rhs;
    logic              w_below;
    logic              r_ovalid;
    t_state            n_state;

    assign w_accept   = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE);
    assign w_load     = (r_state == S_DONE) && (!r_ovalid || !i_out_stall);

    // A push into a full ring first drops the oldest entry.
    assign w_full     = (r_cnt == CNT_FULL);
    assign w_head_inc = (r_head == HEAD_LAST) ? '0 : r_head + 1'b1;
    assign w_head_d   = w_full ? w_head_inc : r_head;
    assign w_cnt_d    = w_full ? r_cnt - 1'b1 : r_cnt;
    assign w_slot_sum = SUM_W'(w_head_d) + SUM_W'(w_cnt_d);
    assign w_slot     = (w_slot_sum >= SUM_WRAP) ? HEAD_W'(w_slot_sum - SUM_WRAP)
                                                 : HEAD_W'(w_slot_sum);
    assign w_base     = AW'(r_sens) * RING_D_A;
    assign w_waddr    = w_base + AW'(w_slot);
    assign w_raddr    = w_base + AW'(r_head);

    srrg_ram #(
        .WIDTH (TIME_W),
        .DEPTH (MEM_D)
    ) u_stamp_ram (
        .i_clk   (i_clk),
        .i_we    (r_state == S_PUSH),
        .i_waddr (w_waddr),
        .i_wdata (r_time),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    // The RAM data in the check state is always the oldest held stamp.
    assign w_age   = r_time - w_rdata;
    assign w_prune = (r_cnt > CNT_TWO) && (w_age > TIME_W'(w_window));

    assign w_few     = CMP_W'(r_cnt) < CMP_W'(w_need);
    assign w_no_rate = (r_cnt < CNT_TWO) || (r_span == '0)
                    || (r_span[TIME_W-1:MUL_B_W*2] != '0);

    always_comb begin
        w_mul_a = MUL_A_W'(w_thr);
        w_mul_b = r_span[MUL_B_W-1:0];
        if (r_state == S_MLHS) begin
            w_mul_a = RATE_SCALE;
            w_mul_b = MUL_B_W'(r_cnt - CNT_ONE);
        end else if (r_state == S_MHI) begin
            w_mul_b = r_span[2*MUL_B_W-1:MUL_B_W];
        end
    end

    // Threshold times span, rebuilt from its low and high partial products.
    assign w_rhs   = RHS_W'(r_acc) + (RHS_W'(r_prod) << MUL_B_W);
    assign w_below = RHS_W'(r_lhs) < w_rhs;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (w_accept) n_state = S_PUSH;
            S_PUSH: n_state = S_RD;
            S_RD:   n_state = S_CHK;
            S_CHK:  n_state = w_prune ? S_RD : S_MLHS;
            S_MLHS: begin
                if ((r_sens == SENS_ULTRA) || w_few || w_no_rate) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MLO;
                end
            end
            S_MLO:  n_state = S_MHI;
            S_MHI:  n_state = S_CMP;
            S_CMP: begin
                if (w_below || (t_thr_sel'(r_k) == THR_EXC)) begin
                    n_state = S_DONE;
                end else begin
                    n_state = S_MLO;
                end
            end
            S_DONE: if (w_load) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            for (int i = 0; i < NUM_SENSORS; i++) begin
                r_head_a[i] <= '0;
                r_cnt_a[i]  <= '0;
            end
        end else begin
            r_state <= n_state;
            if (w_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovalid <= 1'b0;
            end
            if ((r_state == S_CHK) && !w_prune) begin
                r_head_a[SIDX_W'(r_sens)] <= r_head;
                r_cnt_a[SIDX_W'(r_sens)]  <= r_cnt;
            end
        end
    end

    // Working and payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= w_mul_a * w_mul_b;
        unique case (r_state)
            S_IDLE: begin
                r_sens <= i_sensor;
                r_time <= i_time_us;
                r_head <= r_head_a[SIDX_W'(i_sensor)];
                r_cnt  <= r_cnt_a[SIDX_W'(i_sensor)];
            end
            S_PUSH: begin
                r_head <= w_head_d;
                r_cnt  <= w_cnt_d + 1'b1;
                r_drop <= w_full;
            end
            S_RD: r_k <= 2'(THR_MIN);
            S_CHK: begin
                if (w_prune) begin
                    r_head <= w_head_inc;
                    r_cnt  <= r_cnt - 1'b1;
                end else begin
                    r_span <= (r_cnt >= CNT_TWO) ? w_age : '0;
                end
            end
            S_MLHS: begin
                if (r_sens == SENS_ULTRA) begin
                    r_qual <= Q_NA;
                end else if (w_few) begin
                    r_qual <= Q_ESTAB;
                end else begin
                    r_qual <= Q_BELOW;
                end
            end
            S_MLO: begin
                if (t_thr_sel'(r_k) == THR_MIN) begin
                    r_lhs <= r_prod;
                end
            end
            S_MHI: r_acc <= r_prod;
            S_CMP: begin
                if (w_below) begin
                    case (t_thr_sel'(r_k))
                        THR_MIN:  r_qual <= Q_BELOW;
                        THR_GOOD: r_qual <= Q_MINIMUM;
                        default:  r_qual <= Q_GOOD;
                    endcase
                end else if (t_thr_sel'(r_k) == THR_EXC) begin
                    r_qual <= Q_EXCELLENT;
                end else begin
                    r_k <= r_k + 1'b1;
                end
            end
            S_DONE: begin
                if (w_load) begin
                    o_sensor_out    <= r_sens;
                    o_quality       <= r_qual;
                    o_rate_ok       <= (r_qual != Q_BELOW);
                    o_sample_count  <= SAMPLES_W'(r_cnt);
                    o_span_us       <= r_span;
                    o_overflow_drop <= r_drop;
                end
            end
            default: r_k <= r_k;
        endcase
    end

    assign o_out_valid = r_ovalid;

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_cnt_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_cnt <= CNT_FULL))
        else $error("ring count exceeds ring depth");

    a_head_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> (r_head <= HEAD_LAST))
        else $error("ring head out of range");

    a_na_ultra: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> ((o_sensor_out == SENS_ULTRA) == (o_quality == Q_NA)))
        else $error("ungraded quality does not match the ultrasonic sensor");

    a_accept_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> (r_state == S_PUSH))
        else $error("accepted word did not start a push");

endmodule
`default_nettype wire

// ===== dv/srrg_grade_monitor.sv =====
`timescale 1ns / 1ps
// ============================================================================
// srrg_grade_monitor
// Watches the receipt and grade channels of the sensor receive-rate grader,
// follows register writes on the configuration port, predicts the grade of
// every accepted receipt word and compares each accepted grade word with it.
// ============================================================================
module srrg_grade_monitor
    import srrg_pkg::*;
#(
    parameter int RING_DEPTH  = RING_DEPTH_DEF,
    parameter int NUM_SENSORS = NUM_SENSORS_DEF
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    // Receipt channel
    input  logic                 i_in_valid,
    input  logic                 i_in_stall,
    input  logic [SENSOR_W-1:0]  i_sensor,
    input  logic [TIME_W-1:0]    i_time_us,
    // Grade channel
    input  logic                 i_out_valid,
    input  logic                 i_out_stall,
    input  logic [SENSOR_W-1:0]  i_sensor_out,
    input  logic [QUAL_W-1:0]    i_quality,
    input  logic                 i_rate_ok,
    input  logic [SAMPLES_W-1:0] i_sample_count,
    input  logic [TIME_W-1:0]    i_span_us,
    input  logic                 i_overflow_drop,
    // Configuration port
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [APB_AW-1:0]    paddr,
    input  logic [APB_DW-1:0]    pwdata,
    input  logic                 pready,
    output int                   o_grades_due,
    output int                   o_mismatches
);

    typedef struct packed {
        t_sensor                sensor;
        t_quality               quality;
        logic                   rate_ok;
        logic [SAMPLES_W-1:0]   count;
        logic [TIME_W-1:0]      span;
        logic                   dropped;
    } t_grade;

    logic [WINDOW_W-1:0]  window_us;
    logic [SAMPLES_W-1:0] min_samples;
    logic [THR_W-1:0]     tof_min, tof_good, tof_exc;
    logic [THR_W-1:0]     depth_min, depth_good, depth_exc;

    logic [TIME_W-1:0] stamps [NUM_SENSORS][RING_DEPTH];
    int unsigned       head [NUM_SENSORS];
    int unsigned       fill [NUM_SENSORS];

    t_grade grades_due [$];
    int     mismatches = 0;
    int     due_count  = 0;

    assign o_grades_due = due_count;
    assign o_mismatches = mismatches;

    function automatic logic [TIME_W-1:0] stamp_at(int unsigned s, int unsigned off);
        return stamps[s][(head[s] + off) % RING_DEPTH];
    endfunction

    function automatic void drop_oldest(int unsigned s);
        head[s] = (head[s] + 1) % RING_DEPTH;
        fill[s] = fill[s] - 1;
    endfunction

    // The rate (n-1)/span in Hz is below thr in mHz when (n-1)*1e9 < thr*span.
    // A span of 2^44 or more makes the right side exceed any possible left side.
    function automatic bit rate_under(int unsigned n, logic [TIME_W-1:0] span,
                                      logic [THR_W-1:0] thr);
        logic [63:0] lhs;
        logic [63:0] rhs;
        if (n < 2 || span == '0)
            return 1'b1;
        if (span[TIME_W-1:44] != '0)
            return 1'b1;
        lhs = 64'(n - 1) * 64'd1000000000;
        rhs = 64'(thr) * 64'(span);
        return lhs < rhs;
    endfunction

    function automatic t_grade grade_receipt(t_sensor s, logic [TIME_W-1:0] t);
        t_grade            g;
        int unsigned       si;
        int unsigned       n;
        int unsigned       need;
        logic [TIME_W-1:0] window;
        logic [TIME_W-1:0] age;
        logic [TIME_W-1:0] span;
        logic [THR_W-1:0]  mn, gd, ex;
        si     = 32'(s);
        window = (window_us == '0) ? TIME_W'(WINDOW_SUB) : TIME_W'(window_us);
        need   = 32'((min_samples >= MIN_SAMPLES_LOW) ? min_samples : MIN_SAMPLES_SUB);
        g.dropped = 1'b0;
        if (fill[si] >= RING_DEPTH) begin
            drop_oldest(si);
            g.dropped = 1'b1;
        end
        stamps[si][(head[si] + fill[si]) % RING_DEPTH] = t;
        fill[si] = fill[si] + 1;
        // Ages wrap at 48 bits, so a step backwards looks very old.
        age = t - stamp_at(si, 0);
        while (fill[si] > 2 && age > window) begin
            drop_oldest(si);
            age = t - stamp_at(si, 0);
        end
        n    = fill[si];
        span = '0;
        if (n >= 2)
            span = stamp_at(si, n - 1) - stamp_at(si, 0);
        if (s == SENS_DEPTH) begin
            mn = depth_min;
            gd = depth_good;
            ex = depth_exc;
        end else begin
            mn = tof_min;
            gd = tof_good;
            ex = tof_exc;
        end
        if (mn == '0)
            mn = MIN_MHZ_SUB;
        if (gd < mn)
            gd = mn;
        if (ex < gd)
            ex = gd;
        if (s == SENS_ULTRA)
            g.quality = Q_NA;
        else if (n < need)
            g.quality = Q_ESTAB;
        else if (rate_under(n, span, mn))
            g.quality = Q_BELOW;
        else if (rate_under(n, span, gd))
            g.quality = Q_MINIMUM;
        else if (rate_under(n, span, ex))
            g.quality = Q_GOOD;
        else
            g.quality = Q_EXCELLENT;
        g.sensor  = s;
        g.rate_ok = (g.quality != Q_BELOW);
        g.count   = SAMPLES_W'(n);
        g.span    = span;
        return g;
    endfunction

    task automatic report(string name, logic [63:0] want, logic [63:0] got);
        if (want !== got) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_grade want;
        if (!i_rst_n) begin
            window_us   = WINDOW_RST;
            min_samples = MIN_SAMPLES_RST;
            tof_min     = TOF_MIN_RST;
            tof_good    = TOF_GOOD_RST;
            tof_exc     = TOF_EXC_RST;
            depth_min   = DEPTH_MIN_RST;
            depth_good  = DEPTH_GOOD_RST;
            depth_exc   = DEPTH_EXC_RST;
            for (int s = 0; s < NUM_SENSORS; s++) begin
                head[s] = 0;
                fill[s] = 0;
            end
            grades_due.delete();
            due_count = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (t_reg_idx'(paddr[APB_AW-1:2]))
                    REG_WINDOW:      window_us   = pwdata[WINDOW_W-1:0];
                    REG_MIN_SAMPLES: min_samples = pwdata[SAMPLES_W-1:0];
                    REG_TOF_MIN:     tof_min     = pwdata[THR_W-1:0];
                    REG_TOF_GOOD:    tof_good    = pwdata[THR_W-1:0];
                    REG_TOF_EXC:     tof_exc     = pwdata[THR_W-1:0];
                    REG_DEPTH_MIN:   depth_min   = pwdata[THR_W-1:0];
                    REG_DEPTH_GOOD:  depth_good  = pwdata[THR_W-1:0];
                    REG_DEPTH_EXC:   depth_exc   = pwdata[THR_W-1:0];
                    default: ;
                endcase
            end
            if (i_out_valid && !i_out_stall) begin
                if (grades_due.size() == 0) begin
                    $error("grade word arrived with no receipt outstanding");
                    mismatches++;
                end else begin
                    want = grades_due[0];
                    grades_due.delete(0);
                    report("sensor_out", 64'(want.sensor), 64'(i_sensor_out));
                    report("quality", 64'(want.quality), 64'(i_quality));
                    report("rate_ok", 64'(want.rate_ok), 64'(i_rate_ok));
                    report("sample_count", 64'(want.count), 64'(i_sample_count));
                    report("span_us", 64'(want.span), 64'(i_span_us));
                    report("overflow_drop", 64'(want.dropped), 64'(i_overflow_drop));
                end
            end
            if (i_in_valid && !i_in_stall)
                grades_due.insert(grades_due.size(),
                                  grade_receipt(t_sensor'(i_sensor), i_time_us));
            due_count = grades_due.size();
        end
    end

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ============================================================================
// tb
// Regression for the sensor receive-rate grader: directed receipts, then
// phases of random receipt streams under different register settings, with
// random idling on both channels and one long hold on the grade channel.
// ============================================================================
module tb;
    import srrg_pkg::*;

    localparam int          LIMIT           = 2000000;
    localparam int          HOLD_CYCLES     = 400;
    localparam int          RANDOM_PHASES   = 10;
    localparam int          WORDS_PER_PHASE = 95;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [SENSOR_W-1:0]  i_sensor;
    logic [TIME_W-1:0]    i_time_us;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [SENSOR_W-1:0]  o_sensor_out;
    logic [QUAL_W-1:0]    o_quality;
    logic                 o_rate_ok;
    logic [SAMPLES_W-1:0] o_sample_count;
    logic [TIME_W-1:0]    o_span_us;
    logic                 o_overflow_drop;
    logic                 psel;
    logic                 penable;
    logic                 pwrite;
    logic [APB_AW-1:0]    paddr;
    logic [APB_DW-1:0]    pwdata;
    logic [APB_DW-1:0]    prdata;
    logic                 pready;

    int                   grades_due;
    int                   mismatches;
    int unsigned          cycles = 0;

    logic [TIME_W-1:0]    now_us;
    int unsigned          tick;
    bit                   no_idle  = 1'b0;
    bit                   hold_req = 1'b0;
    int                   hold_left = 0;

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    sensor_receive_rate_grader_unit DUT (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_sensor        (i_sensor),
        .i_time_us       (i_time_us),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_sensor_out    (o_sensor_out),
        .o_quality       (o_quality),
        .o_rate_ok       (o_rate_ok),
        .o_sample_count  (o_sample_count),
        .o_span_us       (o_span_us),
        .o_overflow_drop (o_overflow_drop),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    srrg_grade_monitor monitor (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_in_valid      (i_in_valid),
        .i_in_stall      (o_in_stall),
        .i_sensor        (i_sensor),
        .i_time_us       (i_time_us),
        .i_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .i_sensor_out    (o_sensor_out),
        .i_quality       (o_quality),
        .i_rate_ok       (o_rate_ok),
        .i_sample_count  (o_sample_count),
        .i_span_us       (o_span_us),
        .i_overflow_drop (o_overflow_drop),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .pready          (pready),
        .o_grades_due    (grades_due),
        .o_mismatches    (mismatches)
    );

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("sensor_receive_rate_grader_unit regression: fail");
            $finish;
        end
    end

    // Grade channel consumer. A hold request stalls it for a long stretch so
    // that the block backs up into its receipt channel.
    initial begin
        int r;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else if (hold_req) begin
                hold_req  = 1'b0;
                hold_left = HOLD_CYCLES - 1;
                i_out_stall <= 1'b1;
            end else if (no_idle) begin
                i_out_stall <= 1'b0;
            end else begin
                r = $urandom_range(0, 99);
                if (r < 3) begin
                    hold_left = $urandom_range(8, 40);
                    i_out_stall <= 1'b1;
                end else begin
                    i_out_stall <= (r < 30);
                end
            end
        end
    end

    task automatic write_reg(t_reg_idx idx, logic [APB_DW-1:0] value);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_AW'(idx) << 2;
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic load_settings(logic [31:0] window, logic [31:0] need,
                                 logic [31:0] t_min, logic [31:0] t_good,
                                 logic [31:0] t_exc, logic [31:0] d_min,
                                 logic [31:0] d_good, logic [31:0] d_exc);
        write_reg(REG_WINDOW, window);
        write_reg(REG_MIN_SAMPLES, need);
        write_reg(REG_TOF_MIN, t_min);
        write_reg(REG_TOF_GOOD, t_good);
        write_reg(REG_TOF_EXC, t_exc);
        write_reg(REG_DEPTH_MIN, d_min);
        write_reg(REG_DEPTH_GOOD, d_good);
        write_reg(REG_DEPTH_EXC, d_exc);
    endtask

    task automatic send_receipt(t_sensor s, logic [TIME_W-1:0] t);
        int gap;
        int r;
        gap = 0;
        if (!no_idle) begin
            r = $urandom_range(0, 99);
            if (r >= 92)
                gap = $urandom_range(8, 40);
            else if (r >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_sensor   <= s;
        i_time_us  <= t;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Mostly steady receipts around the phase's tick, with repeats, tiny
    // steps, jumps far past the window and the odd step backwards.
    task automatic random_receipt();
        t_sensor           s;
        logic [TIME_W-1:0] t;
        int                r;
        s = t_sensor'($urandom_range(0, 3));
        r = $urandom_range(0, 99);
        if (r < 70)
            now_us += TIME_W'($urandom_range(tick / 2, tick + tick / 2));
        else if (r < 78)
            now_us = now_us;
        else if (r < 85)
            now_us += TIME_W'($urandom_range(1, 3));
        else if (r < 91)
            now_us += TIME_W'($urandom);
        else if (r < 93)
            now_us += TIME_W'({$urandom_range(0, 65535), $urandom});
        t = now_us;
        if (r >= 93)
            t = now_us - TIME_W'($urandom_range(1, 4 * tick));
        send_receipt(s, t);
    endtask

    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (grades_due != 0) @(negedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        int unsigned t_min, d_min, t_good, d_good, window;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_sensor   = '0;
        i_time_us  = '0;
        psel       = 1'b0;
        penable    = 1'b0;
        pwrite     = 1'b0;
        paddr      = '0;
        pwdata     = '0;
        repeat (2) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed words under the reset settings.
        send_receipt(SENS_ULTRA, '1);
        send_receipt(SENS_DEPTH, '0);
        for (int k = 1; k <= 4; k++)
            send_receipt(SENS_DEPTH, TIME_W'(100000 * k));
        send_receipt(SENS_DEPTH, TIME_W'(400000));
        for (int k = 1; k <= 5; k++)
            send_receipt(SENS_TOF_L, TIME_W'(1000000 * k));
        for (int k = 0; k < 5; k++)
            send_receipt(SENS_TOF_R, TIME_W'(5));
        send_receipt(SENS_TOF_R, '0);
        send_receipt(SENS_TOF_L, 48'h8000_0000_0000);
        send_receipt(SENS_TOF_L, 48'h8000_0001_0000);
        drain();

        now_us = 48'h0000_0100_0000;
        for (int phase = 1; phase <= RANDOM_PHASES; phase++) begin
            case (phase)
                1: begin
                    load_settings(1, 2, 1, 1000000, 1000000, 1, 1, 1);
                    tick = 500;
                end
                2: begin
                    // Zero ToF minimum, and depth thresholds in falling order.
                    load_settings(60000000, 64, 0, 0, 0, 1000000, 500000, 1000);
                    tick = 250;
                end
                3: begin
                    // Zero window and a too small sample need take defaults.
                    load_settings(0, 0, 32'hFFFFF, 3000, 2000, 2500, 2500, 32'hFFFFF);
                    tick   = 25000;
                    now_us = 48'hFFFF_FFFF_FFFF - 48'd1500000;
                end
                4: begin
                    load_settings(32'h3FFFFFF, 32'h7F, 5000, 8000, 9000, 5000, 10000, 12000);
                    tick   = 20000;
                    now_us = TIME_W'({$urandom_range(0, 65535), $urandom});
                end
                5: begin
                    load_settings(500000, 1, 20000, 30000, 40000, 20000, 30000, 40000);
                    tick = 12000;
                end
                default: begin
                    t_min  = $urandom_range(1000, 200000);
                    d_min  = t_min * $urandom_range(50, 150) / 100;
                    t_good = t_min + $urandom_range(0, t_min);
                    d_good = d_min + $urandom_range(0, d_min);
                    tick   = $urandom_range(150000000, 300000000) / t_min;
                    window = tick * $urandom_range(8, 200);
                    if (window > 60000000)
                        window = 60000000;
                    load_settings(window, $urandom_range(2, 12), t_min, t_good,
                                  t_good + $urandom_range(0, t_min), d_min, d_good,
                                  d_good + $urandom_range(0, d_min));
                    if (phase % 2 == 0)
                        now_us = TIME_W'({$urandom_range(0, 65535), $urandom});
                end
            endcase
            no_idle  = (phase % 3 == 0);
            hold_req = (phase == 3);
            repeat (WORDS_PER_PHASE) random_receipt();
            drain();
        end

        repeat (10) @(posedge i_clk);
        if (mismatches == 0)
            $display("sensor_receive_rate_grader_unit regression: pass");
        else
            $display("sensor_receive_rate_grader_unit regression: fail");
        $finish;
    end

endmodule
